@@ sv/rgfm_pkg.sv @@
// rgfm_pkg: shared types and constants for the ramped gain feedback mixer
// no dependencies; imported by every rgfm module and the core top level
package rgfm_pkg;

  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned GAIN_W   = 17;

  // unity gain in Q16 and the ramp granularity mask (multiples of 128)
  localparam logic [GAIN_W-1:0] UNITY_GAIN      = 17'd65536;
  localparam logic [GAIN_W-1:0] GAIN_ALIGN_MASK = 17'h1FF80;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic [GAIN_W-1:0]          gain_t;

  // one sample pair with the gain that applies to it
  typedef struct packed {
    sample_t direct;
    sample_t feedback;
    gain_t   gain;
  } mix_req_t;

endpackage

@@ sv/rgfm_gain_ctrl.sv @@
// rgfm_gain_ctrl: block position counter and linear gain ramp state
// depends on rgfm_pkg; produces the gain for each accepted sample pair
module rgfm_gain_ctrl import rgfm_pkg::*; #(
  parameter int unsigned BLOCK_SAMPLES = 128
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  accept_i,
  input  gain_t target_gain_i,
  output gain_t gain_o
);

  localparam int unsigned POS_W = (BLOCK_SAMPLES > 1) ? $clog2(BLOCK_SAMPLES) : 1;
  localparam logic [POS_W-1:0] LAST_POS = POS_W'(BLOCK_SAMPLES - 1);

  gain_t            cur_q, cur_d;
  gain_t            run_q, run_d;
  gain_t            rem_q, rem_d;
  logic             down_q, down_d;
  logic             active_q, active_d;
  logic [POS_W-1:0] pos_q, pos_d;

  gain_t clamped, held_target, run_base, rem_start, rem_mid;
  logic  block_start, block_end, ramp_start, active_mid, down_mid;

  // target conditioning and ramp update for the current transfer
  always_comb begin
    block_start = (pos_q == '0);
    block_end   = (pos_q == LAST_POS);
    clamped     = (target_gain_i > UNITY_GAIN) ? UNITY_GAIN : target_gain_i;
    held_target = clamped & GAIN_ALIGN_MASK;
    run_base    = block_start ? cur_q : run_q;
    ramp_start  = block_start && !active_q && (held_target != cur_q);
    rem_start   = (held_target < cur_q) ? (cur_q - held_target) : (held_target - cur_q);
    active_mid  = active_q || ramp_start;
    down_mid    = ramp_start ? (held_target < cur_q) : down_q;
    rem_mid     = ramp_start ? rem_start : rem_q;

    run_d = run_base;
    rem_d = rem_mid;
    if (active_mid && (rem_mid != '0)) begin
      run_d = down_mid ? (run_base - 1'b1) : (run_base + 1'b1);
      rem_d = rem_mid - 1'b1;
    end
    down_d = down_mid;

    gain_o = active_mid ? run_d : cur_q;

    // block end: commit ramp progress and retire a finished ramp
    pos_d    = block_end ? '0 : (pos_q + 1'b1);
    cur_d    = cur_q;
    active_d = active_mid;
    if (block_end && active_mid) begin
      cur_d = run_d;
      if (rem_d == '0) begin
        active_d = 1'b0;
      end
    end
  end

  // state registers, updated once per accepted transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q    <= '0;
      run_q    <= '0;
      rem_q    <= '0;
      down_q   <= 1'b0;
      active_q <= 1'b0;
      pos_q    <= '0;
    end else if (accept_i) begin
      cur_q    <= cur_d;
      run_q    <= run_d;
      rem_q    <= rem_d;
      down_q   <= down_d;
      active_q <= active_d;
      pos_q    <= pos_d;
    end
  end

  // pending ramp steps only exist while a ramp runs
  assert property (@(posedge clk_i) disable iff (!rst_ni) (rem_q != '0) |-> active_q)
    else $error("ramp steps pending without an active ramp");

  // committed gain never leaves the unity range
  assert property (@(posedge clk_i) disable iff (!rst_ni) cur_q <= UNITY_GAIN)
    else $error("block gain above unity");

  // running gain stays in range as well
  assert property (@(posedge clk_i) disable iff (!rst_ni) run_q <= UNITY_GAIN)
    else $error("running gain above unity");

endmodule

@@ sv/rgfm_mix_dp.sv @@
// rgfm_mix_dp: input register, Q16 scale and saturating add, result register
// depends on rgfm_pkg; carries the valid/stall handshake of both stages
module rgfm_mix_dp import rgfm_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     req_valid_i,
  input  mix_req_t req_i,
  output logic     req_stall_o,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output sample_t  mixed_o
);

  localparam int unsigned PROD_W   = GAIN_W + 1 + SAMPLE_W;
  localparam int unsigned SCALED_W = PROD_W - 16;

  localparam logic signed [SCALED_W-1:0] SCALED_MAX = SCALED_W'(32767);
  localparam logic signed [SCALED_W-1:0] SCALED_MIN = -SCALED_W'(32768);
  localparam logic signed [SAMPLE_W:0]   SUM_MAX    = (SAMPLE_W+1)'(32767);
  localparam logic signed [SAMPLE_W:0]   SUM_MIN    = -(SAMPLE_W+1)'(32768);

  logic     stage_valid_q;
  mix_req_t stage_q;
  logic     out_valid_q;
  sample_t  mixed_q, mixed_d;
  logic     out_ready;

  logic signed [GAIN_W:0]     gain_s;
  logic signed [PROD_W-1:0]   prod;
  logic signed [SCALED_W-1:0] scaled;
  sample_t                    scaled_sat;
  logic signed [SAMPLE_W:0]   sum;

  // handshake: the result register frees the input register
  assign out_ready   = !out_valid_q || !out_stall_i;
  assign req_stall_o = stage_valid_q && !out_ready;
  assign out_valid_o = out_valid_q;
  assign mixed_o     = mixed_q;

  // floor((gain * feedback) / 65536), then saturating sums
  always_comb begin
    gain_s = $signed({1'b0, stage_q.gain});
    prod   = gain_s * $signed(stage_q.feedback);
    scaled = prod[PROD_W-1:16];
    if (scaled > SCALED_MAX) begin
      scaled_sat = sample_t'(32767);
    end else if (scaled < SCALED_MIN) begin
      scaled_sat = sample_t'(-32768);
    end else begin
      scaled_sat = scaled[SAMPLE_W-1:0];
    end
    sum = $signed({stage_q.direct[SAMPLE_W-1], stage_q.direct})
        + $signed({scaled_sat[SAMPLE_W-1], scaled_sat});
    if (sum > SUM_MAX) begin
      mixed_d = sample_t'(32767);
    end else if (sum < SUM_MIN) begin
      mixed_d = sample_t'(-32768);
    end else begin
      mixed_d = sum[SAMPLE_W-1:0];
    end
  end

  // valid flags of both stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_valid_q <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      if (!req_stall_o) begin
        stage_valid_q <= req_valid_i;
      end
      if (out_ready) begin
        out_valid_q <= stage_valid_q;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (req_valid_i && !req_stall_o) begin
      stage_q <= req_i;
    end
    if (out_ready && stage_valid_q) begin
      mixed_q <= mixed_d;
    end
  end

endmodule

@@ sv/ramped_gain_feedback_mixer_core.sv @@
// ramped_gain_feedback_mixer_core: top level of the ramped gain feedback mixer
// depends on rgfm_pkg, rgfm_gain_ctrl and rgfm_mix_dp
//
// Mixes a direct sample with a feedback sample scaled by a Q16 gain and
// saturates to 16 bits. The target gain is sampled at the first sample of a
// block of BLOCK_SAMPLES transfers if no ramp runs, clamped to unity and floored
// to a multiple of 128; the gain then ramps toward it one unit per sample.
// One transfer is accepted per clock while in_stall_o is low; each result
// passes the input register, then the 17 by 16 bit multiply and the
// saturating add, then the result register.
module ramped_gain_feedback_mixer_core import rgfm_pkg::*; #(
  parameter int unsigned BLOCK_SAMPLES = 128
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_stall_o,
  input  sample_t direct_sample_i,
  input  sample_t feedback_sample_i,
  input  gain_t   target_gain_i,
  output logic    out_valid_o,
  input  logic    out_stall_i,
  output sample_t mixed_sample_o
);

  logic     in_accept;
  logic     req_stall;
  gain_t    gain;
  mix_req_t req;

  assign in_stall_o = req_stall;
  assign in_accept  = in_valid_i && !req_stall;

  // gain ramp state advances on every input transfer
  rgfm_gain_ctrl #(
    .BLOCK_SAMPLES(BLOCK_SAMPLES)
  ) u_gain_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (in_accept),
    .target_gain_i(target_gain_i),
    .gain_o       (gain)
  );

  always_comb begin
    req.direct   = direct_sample_i;
    req.feedback = feedback_sample_i;
    req.gain     = gain;
  end

  // scale and mix datapath
  rgfm_mix_dp u_mix_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_valid_i(in_valid_i),
    .req_i      (req),
    .req_stall_o(req_stall),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .mixed_o    (mixed_sample_o)
  );

endmodule
